FILE: hdl/pmti_pkg.sv
// Point mass thrust integrator: shared types and constants.
// No dependencies; imported by point_mass_thrust_integrator_core.
`default_nettype none
package pmti_pkg;

   // action codes carried in req_tuser
   localparam logic [1:0] ACT_STORE   = 2'd0;
   localparam logic [1:0] ACT_TICK    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   // register indexes on the csr port
   localparam logic [2:0] CSR_MAX_SPEED  = 3'd0;
   localparam logic [2:0] CSR_GAIN       = 3'd1;
   localparam logic [2:0] CSR_OBS_LEFT   = 3'd2;
   localparam logic [2:0] CSR_OBS_TOP    = 3'd3;
   localparam logic [2:0] CSR_OBS_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_OBS_HEIGHT = 3'd5;
   localparam logic [2:0] CSR_GENE_COUNT = 3'd6;

   // reset values, Q15.8 pixels and Q4.12
   localparam logic signed [23:0] START_X    = 24'sd163840;
   localparam logic signed [23:0] START_Y    = 24'sd153600;
   localparam logic signed [25:0] BOX_SIZE   = 26'sd640;
   localparam logic [15:0]        MAX_SPEED_RST = 16'd8192;
   localparam logic [15:0]        GAIN_RST      = 16'd4915;
   localparam logic [8:0]         GENE_CNT_RST  = 9'd256;

   // shared unit iteration counts
   localparam logic [5:0] SQ_LAST  = 6'd26;   // 27 root digits
   localparam logic [5:0] DIV_LAST = 6'd45;   // 46 quotient bits

   typedef enum logic [4:0] {
      S_IDLE, S_MSTEP, S_MFX, S_MFY, S_SUMF, S_SQRT, S_SQDONE,
      S_MULD, S_LDDIV, S_DIV, S_DIVDONE, S_MVX, S_MVY, S_MMS,
      S_CMP, S_POS, S_CRASH, S_RESP
   } state_type;

   typedef enum logic [1:0] {
      DIV_TX, DIV_TY, DIV_LX, DIV_LY
   } div_sel_type;

endpackage
`default_nettype wire

FILE: hdl/point_mass_thrust_integrator_core.sv
// Point mass thrust integrator, top level: sequencer, shared multiplier,
// shared subtract unit for square root and division, thrust table memory.
// Depends on pmti_pkg.
//
// channel | dir | handshake             | payload
// --------+-----+-----------------------+-------------------------------------
// req     | in  | req_tvalid/req_tready | tuser action, tdata item fields
// rsp     | out | rsp_tvalid/rsp_tready | tdata state after the item
// csr     | in  | csr_we                | csr_addr index, csr_wdata value
//
// Store, restart and unused actions: response word valid the cycle after
// acceptance. A tick on a crashed mass passes through S_CRASH before S_RESP.
// A live tick runs one 27-step root and two 46-step divides (no divides
// for a zero thrust vector) through the one shared 31-bit subtractor; a
// speed above the limit adds another root and two divides.
// Synchronous active-high reset; the thrust table is not cleared.
// req_tready is low from acceptance until the response word is taken.
`default_nettype none
module point_mass_thrust_integrator_core #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // gene_index[7:0], force_x[23:8], force_y[39:24], time_step[55:40]
   input  wire logic [55:0]  req_tdata,
   // action[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pos_x[23:0], pos_y[47:24], vel_x[64:48], vel_y[81:65], crashed[82],
   // next_gene[90:83], zero fill above
   output logic [95:0]       rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [23:0]  csr_wdata
);
   import pmti_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;

   function automatic logic [AW-1:0] slot_mod(input logic [7:0] idx);
      int r;
      r = int'(idx);
      for (int k = 7; k >= 0; k--) begin
         if (r >= (TABLE_DEPTH << k)) r = r - (TABLE_DEPTH << k);
      end
      return AW'(r);
   endfunction

   state_type state_ff, state_in;
   div_sel_type dsel_ff, dsel_in;

   // configuration
   logic [15:0] ms_ff, gain_ff;
   logic signed [23:0] left_ff, top_ff;
   logic [22:0] width_ff, height_ff;
   logic [8:0]  gcnt_ff;

   // architectural state
   logic signed [23:0] px_ff, py_ff, px_in, py_in;
   logic signed [18:0] vx_ff, vy_ff, vx_in, vy_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic crash_ff, crash_in;

   // datapath
   logic [15:0] dt_ff, dt_in, step_ff, step_in;
   logic [37:0] acc_ff, acc_in;
   logic signed [37:0] prod_ff;
   logic signed [18:0] mul_a, mul_b;
   logic [53:0] rad_ff, rad_in;
   logic [28:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [26:0] root_ff, root_in;
   logic [45:0] nq_ff, nq_in;
   logic neg_ff, neg_in, sqsel_ff, sqsel_in;
   logic [5:0] cnt_ff, cnt_in;

   // thrust table
   logic [31:0] tbl_mem [TABLE_DEPTH];
   logic [31:0] rd_ff;
   logic        tbl_we;
   logic [AW-1:0] tbl_wa;

   logic req_acc;
   logic signed [18:0] fx, fy;

   // shared subtract unit
   logic [30:0] alu_a, alu_b;
   logic [31:0] alu_d;
   logic alu_ge;

   // helpers
   logic [37:0] prod_abs;
   logic [18:0] q_mag, q_s;
   logic signed [25:0] nx_x, nx_y, lo_x, hi_x, lo_y, hi_y;
   logic ov;
   logic [CW-1:0] p1, cnt_eff, ptr_w;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign req_acc    = req_tvalid && req_tready;
   assign fx = 19'(signed'(rd_ff[15:0]));
   assign fy = 19'(signed'(rd_ff[31:16]));

   always_comb begin
      if (state_ff == S_SQRT) begin
         alu_a = {rem_ff, rad_ff[53:52]};
         alu_b = {2'b00, root_ff, 2'b01};
      end else begin
         alu_a = {1'b0, rem_ff, nq_ff[45]};
         alu_b = {2'b00, dvs_ff};
      end
      alu_d  = {1'b0, alu_a} - {1'b0, alu_b};
      alu_ge = ~alu_d[31];
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MSTEP: begin mul_a = {3'b0, gain_ff}; mul_b = {3'b0, dt_ff}; end
         S_MFX:   begin mul_a = fx; mul_b = fx; end
         S_MFY:   begin mul_a = fy; mul_b = fy; end
         S_MULD: begin
            unique case (dsel_ff)
               DIV_TX: begin mul_a = fx;    mul_b = {3'b0, step_ff}; end
               DIV_TY: begin mul_a = fy;    mul_b = {3'b0, step_ff}; end
               DIV_LX: begin mul_a = vx_ff; mul_b = {3'b0, ms_ff}; end
               DIV_LY: begin mul_a = vy_ff; mul_b = {3'b0, ms_ff}; end
               default: ;
            endcase
         end
         S_MVX:   begin mul_a = vx_ff; mul_b = vx_ff; end
         S_MVY:   begin mul_a = vy_ff; mul_b = vy_ff; end
         S_MMS:   begin mul_a = {3'b0, ms_ff}; mul_b = {3'b0, ms_ff}; end
         default: ;
      endcase
   end

   // position rounding, crash test, pointer wrap
   function automatic logic signed [25:0] pos_add(input logic signed [23:0] p,
                                                   input logic signed [18:0] v);
      logic [18:0] va;
      logic [19:0] r;
      logic signed [25:0] s;
      va = v[18] ? 19'(-v) : 19'(v);
      r  = {1'b0, va} + 20'd8;
      s  = v[18] ? 26'(p) - 26'(r[19:4]) : 26'(p) + 26'(r[19:4]);
      if (s > 26'sd8388607) s = 26'sd8388607;
      else if (s < -26'sd8388608) s = -26'sd8388608;
      return s;
   endfunction

   always_comb begin
      logic signed [25:0] pe_x, le_x, pe_y, le_y;
      prod_abs = prod_ff[37] ? 38'(-prod_ff) : 38'(prod_ff);
      q_mag    = nq_ff[18:0];
      q_s      = neg_ff ? 19'(-q_mag) : q_mag;
      nx_x     = pos_add(px_ff, vx_ff);
      nx_y     = pos_add(py_ff, vy_ff);
      pe_x = 26'(px_ff) + BOX_SIZE;
      le_x = 26'(left_ff) + 26'(signed'({1'b0, width_ff}));
      pe_y = 26'(py_ff) + BOX_SIZE;
      le_y = 26'(top_ff) + 26'(signed'({1'b0, height_ff}));
      lo_x = (26'(px_ff) > 26'(left_ff)) ? 26'(px_ff) : 26'(left_ff);
      hi_x = (pe_x < le_x) ? pe_x : le_x;
      lo_y = (26'(py_ff) > 26'(top_ff)) ? 26'(py_ff) : 26'(top_ff);
      hi_y = (pe_y < le_y) ? pe_y : le_y;
      ov   = (lo_x < hi_x) && (lo_y < hi_y);
      cnt_eff = (gcnt_ff == 9'd0 || CW'(gcnt_ff) > CW'(TABLE_DEPTH))
                ? CW'(TABLE_DEPTH) : CW'(gcnt_ff);
      p1 = CW'(ptr_ff) + CW'(1);
      if (p1 == CW'(TABLE_DEPTH)) p1 = '0;
      if (p1 >= cnt_eff) p1 = '0;
      ptr_w = CW'(ptr_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tuser == ACT_TICK)
                  state_in = crash_ff ? S_CRASH : S_MSTEP;
               else
                  state_in = S_RESP;
            end
         end
         S_MSTEP:  state_in = S_MFX;
         S_MFX:    state_in = S_MFY;
         S_MFY:    state_in = S_SUMF;
         S_SUMF:   state_in = S_SQRT;
         S_SQRT:   if (cnt_ff == SQ_LAST) state_in = S_SQDONE;
         S_SQDONE: state_in = (!sqsel_ff && root_ff == '0) ? S_MVX : S_MULD;
         S_MULD:   state_in = S_LDDIV;
         S_LDDIV:  state_in = S_DIV;
         S_DIV:    if (cnt_ff == DIV_LAST) state_in = S_DIVDONE;
         S_DIVDONE: begin
            unique case (dsel_ff)
               DIV_TX, DIV_LX: state_in = S_MULD;
               DIV_TY:         state_in = S_MVX;
               DIV_LY:         state_in = S_POS;
               default:        state_in = S_POS;
            endcase
         end
         S_MVX:   state_in = S_MVY;
         S_MVY:   state_in = S_MMS;
         S_MMS:   state_in = S_CMP;
         S_CMP:   state_in = (acc_ff > 38'(prod_ff)) ? S_SQRT : S_POS;
         S_POS:   state_in = S_CRASH;
         S_CRASH: state_in = S_RESP;
         S_RESP:  if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and state updates
   always_comb begin
      px_in = px_ff;  py_in = py_ff;
      vx_in = vx_ff;  vy_in = vy_ff;
      ptr_in = ptr_ff; crash_in = crash_ff;
      dt_in = dt_ff;  step_in = step_ff;
      acc_in = acc_ff; rad_in = rad_ff;
      rem_in = rem_ff; root_in = root_ff;
      nq_in = nq_ff;  dvs_in = dvs_ff;
      neg_in = neg_ff; sqsel_in = sqsel_ff;
      cnt_in = cnt_ff; dsel_in = dsel_ff;
      tbl_we = 1'b0;
      tbl_wa = slot_mod(req_tdata[7:0]);
      unique case (state_ff)
         S_IDLE: begin
            dt_in = req_tdata[55:40];
            if (req_acc) begin
               if (req_tuser == ACT_STORE) tbl_we = 1'b1;
               if (req_tuser == ACT_RESTART) begin
                  px_in = START_X; py_in = START_Y;
                  vx_in = '0; vy_in = '0;
                  ptr_in = '0; crash_in = 1'b0;
               end
            end
         end
         S_MFX: step_in = prod_ff[31:16];
         S_MFY: acc_in = 38'(prod_ff);
         S_SUMF: begin
            rad_in = {acc_ff + 38'(prod_ff), 16'b0};
            rem_in = '0; root_in = '0; cnt_in = '0;
            sqsel_in = 1'b0;
         end
         S_SQRT: begin
            rem_in  = alu_ge ? alu_d[28:0] : alu_a[28:0];
            root_in = {root_ff[25:0], alu_ge};
            rad_in  = {rad_ff[51:0], 2'b00};
            cnt_in  = cnt_ff + 6'd1;
         end
         S_SQDONE: dsel_in = sqsel_ff ? DIV_LX : DIV_TX;
         S_LDDIV: begin
            neg_in = prod_ff[37];
            nq_in  = {1'b0, prod_abs[35:0], 9'b0} + 46'(root_ff);
            dvs_in = {1'b0, root_ff, 1'b0};
            rem_in = '0;
            cnt_in = '0;
         end
         S_DIV: begin
            rem_in = alu_ge ? alu_d[28:0] : alu_a[28:0];
            nq_in  = {nq_ff[44:0], alu_ge};
            cnt_in = cnt_ff + 6'd1;
         end
         S_DIVDONE: begin
            unique case (dsel_ff)
               DIV_TX: begin vx_in = vx_ff + q_s; dsel_in = DIV_TY; end
               DIV_TY: vy_in = vy_ff + q_s;
               DIV_LX: begin vx_in = q_s; dsel_in = DIV_LY; end
               DIV_LY: vy_in = q_s;
               default: ;
            endcase
         end
         S_MVY: acc_in = 38'(prod_ff);
         S_MMS: acc_in = acc_ff + 38'(prod_ff);
         S_CMP: begin
            rad_in = {acc_ff, 16'b0};
            rem_in = '0; root_in = '0; cnt_in = '0;
            sqsel_in = 1'b1;
         end
         S_POS: begin
            px_in  = nx_x[23:0];
            py_in  = nx_y[23:0];
            ptr_in = p1[AW-1:0];
         end
         S_CRASH: crash_in = ov;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         dsel_ff   <= DIV_TX;
         sqsel_ff  <= 1'b0;
         cnt_ff    <= '0;
         px_ff     <= START_X;
         py_ff     <= START_Y;
         vx_ff     <= '0;
         vy_ff     <= '0;
         ptr_ff    <= '0;
         crash_ff  <= 1'b0;
         ms_ff     <= MAX_SPEED_RST;
         gain_ff   <= GAIN_RST;
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         gcnt_ff   <= GENE_CNT_RST;
      end else begin
         state_ff <= state_in;
         dsel_ff  <= dsel_in;
         sqsel_ff <= sqsel_in;
         cnt_ff   <= cnt_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
         ptr_ff   <= ptr_in;
         crash_ff <= crash_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MAX_SPEED:  ms_ff     <= csr_wdata[15:0];
               CSR_GAIN:       gain_ff   <= csr_wdata[15:0];
               CSR_OBS_LEFT:   left_ff   <= csr_wdata;
               CSR_OBS_TOP:    top_ff    <= csr_wdata;
               CSR_OBS_WIDTH:  width_ff  <= csr_wdata[22:0];
               CSR_OBS_HEIGHT: height_ff <= csr_wdata[22:0];
               CSR_GENE_COUNT: gcnt_ff   <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      dt_ff   <= dt_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      nq_ff   <= nq_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   // thrust table: x in low half, y in high half
   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_wa] <= req_tdata[39:8];
      rd_ff <= tbl_mem[ptr_ff];
   end

   assign rsp_tdata = {5'b0, ptr_w[7:0], crash_ff, vy_ff[16:0], vx_ff[16:0],
                       py_ff, px_ff};

endmodule
`default_nettype wire
